// ===== sv/aswp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package aswp_pkg;

   localparam int MASK_W      = 4;
   localparam int REP_W       = 8;
   localparam int AMP_W       = 15;
   localparam int CMD_W       = 16;
   localparam int LEVEL_W     = 3;
   localparam int POS_W       = 2;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 15;
   localparam int MAX_LEVELS  = 5;

   // full scale in q2.14
   localparam logic [AMP_W-1:0] AMP_MAX = 15'd16384;

   localparam logic [MASK_W-1:0] MASK_RESET = 4'd15;
   localparam logic [REP_W-1:0]  REP_RESET  = 8'd3;

   localparam logic [AMP_W-1:0] AMP_RESET [MAX_LEVELS] = '{
      15'd6554, 15'd9830, 15'd13107, 15'd14746, 15'd16384
   };

   // register map
   localparam logic [CSR_INDEX_W-1:0] CSR_AXIS_ENABLE = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_REPEATS     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_LEVEL0      = 3'd2;

   // axis codes as shown on active_axis
   localparam logic [1:0] AXIS_X1 = 2'd0;
   localparam logic [1:0] AXIS_X2 = 2'd1;
   localparam logic [1:0] AXIS_Y1 = 2'd2;
   localparam logic [1:0] AXIS_Y2 = 2'd3;

   typedef enum logic [1:0] {
      PH_POS  = 2'd0,
      PH_NEG  = 2'd1,
      PH_DONE = 2'd2
   } phase_type;

   typedef struct packed {
      logic at_max;
      logic at_min;
   } req_type;

   typedef struct packed {
      logic signed [CMD_W-1:0] x1_command;
      logic signed [CMD_W-1:0] x2_command;
      logic signed [CMD_W-1:0] y1_command;
      logic signed [CMD_W-1:0] y2_command;
      logic [1:0]              active_axis;
      logic [1:0]              phase;
   } rsp_type;

   typedef struct packed {
      logic [MASK_W-1:0] axis_enable_mask;
      logic [REP_W-1:0]  repeats_per_level;
   } cfg_type;

   typedef struct packed {
      logic             found;
      logic [POS_W-1:0] pos;
   } search_type;

   // first enabled position after pos in the order y2, y1, x2, x1
   function automatic search_type find_after(logic [MASK_W-1:0] mask,
                                             logic [POS_W-1:0] pos);
      search_type r;
      r.found = 1'b0;
      r.pos   = pos;
      for (int p = 3; p >= 0; p--) begin
         if ((POS_W'(p) > pos) && mask[3-p]) begin
            r.found = 1'b1;
            r.pos   = POS_W'(p);
         end
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== sv/aswp_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none

module aswp_cfg #(
   parameter int LEVEL_COUNT = 5
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_wr_en,
   input  wire logic [aswp_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [aswp_pkg::CSR_DATA_W-1:0]     csr_wr_data,
   output aswp_pkg::cfg_type                        cfg,
   output logic [aswp_pkg::AMP_W-1:0]               amp [LEVEL_COUNT]
);

   logic [aswp_pkg::MASK_W-1:0] mask_ff;
   logic [aswp_pkg::REP_W-1:0]  rep_ff;
   logic [aswp_pkg::AMP_W-1:0]  amp_sat;

   // oversized levels clip to full scale on write
   assign amp_sat = (csr_wr_data > aswp_pkg::AMP_MAX) ? aswp_pkg::AMP_MAX : csr_wr_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= aswp_pkg::MASK_RESET;
         rep_ff  <= aswp_pkg::REP_RESET;
      end else if (csr_wr_en) begin
         if (csr_index == aswp_pkg::CSR_AXIS_ENABLE) begin
            mask_ff <= csr_wr_data[aswp_pkg::MASK_W-1:0];
         end
         if (csr_index == aswp_pkg::CSR_REPEATS) begin
            rep_ff <= csr_wr_data[aswp_pkg::REP_W-1:0];
         end
      end
   end

   for (genvar i = 0; i < LEVEL_COUNT; i++) begin : g_level
      logic [aswp_pkg::AMP_W-1:0] amp_ff;

      always_ff @(posedge clock) begin
         if (reset) begin
            amp_ff <= aswp_pkg::AMP_RESET[i];
         end else if (csr_wr_en &&
                      csr_index == aswp_pkg::CSR_LEVEL0 + aswp_pkg::CSR_INDEX_W'(i)) begin
            amp_ff <= amp_sat;
         end
      end

      assign amp[i] = amp_ff;
   end

   assign cfg.axis_enable_mask  = mask_ff;
   assign cfg.repeats_per_level = rep_ff;

endmodule

`default_nettype wire

// ===== sv/aswp_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none

module aswp_seq #(
   parameter int LEVEL_COUNT = 5
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          advance,
   input  aswp_pkg::req_type                  item,
   input  aswp_pkg::cfg_type                  cfg,
   input  wire logic [aswp_pkg::AMP_W-1:0]    amp [LEVEL_COUNT],
   output aswp_pkg::rsp_type                  result
);

   localparam logic [aswp_pkg::LEVEL_W-1:0] LAST_LEVEL = aswp_pkg::LEVEL_W'(LEVEL_COUNT);

   logic [aswp_pkg::POS_W-1:0]   pos_ff, pos_in, pos_a;
   aswp_pkg::phase_type          phase_ff, phase_in, phase_a;
   logic [aswp_pkg::LEVEL_W-1:0] level_ff, level_in, level_a, level_inc;
   logic [aswp_pkg::REP_W-1:0]   rep_ff, rep_in, rep_a, rep_inc;
   aswp_pkg::search_type         first_srch, next_srch;
   logic                         cur_en;
   logic [aswp_pkg::AMP_W-1:0]   amp_sel;
   logic [aswp_pkg::CMD_W-1:0]   drive;
   logic [1:0]                   code;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         phase_ff <= aswp_pkg::PH_POS;
         level_ff <= '0;
         rep_ff   <= '0;
      end else if (advance) begin
         pos_ff   <= pos_in;
         phase_ff <= phase_in;
         level_ff <= level_in;
         rep_ff   <= rep_in;
      end
   end

   // disabled current axis: move on before doing anything else
   always_comb begin
      cur_en     = cfg.axis_enable_mask[~pos_ff];
      first_srch = aswp_pkg::find_after(cfg.axis_enable_mask, pos_ff);
      pos_a      = pos_ff;
      phase_a    = phase_ff;
      level_a    = level_ff;
      rep_a      = rep_ff;
      if (!cur_en) begin
         if (first_srch.found) begin
            pos_a   = first_srch.pos;
            phase_a = aswp_pkg::PH_POS;
            level_a = '0;
            rep_a   = '0;
         end else begin
            phase_a = aswp_pkg::PH_DONE;
         end
      end
   end

   // swing, repeat and level stepping
   always_comb begin
      rep_inc   = rep_a + 1'b1;
      level_inc = level_a + 1'b1;
      next_srch = aswp_pkg::find_after(cfg.axis_enable_mask, pos_a);
      pos_in    = pos_a;
      phase_in  = phase_a;
      level_in  = level_a;
      rep_in    = rep_a;
      case (phase_a)
         aswp_pkg::PH_POS: begin
            if (item.at_max) begin
               phase_in = aswp_pkg::PH_NEG;
            end
         end
         aswp_pkg::PH_NEG: begin
            if (item.at_min) begin
               if (rep_inc < cfg.repeats_per_level) begin
                  rep_in   = rep_inc;
                  phase_in = aswp_pkg::PH_POS;
               end else begin
                  rep_in   = '0;
                  level_in = level_inc;
                  if (level_inc >= LAST_LEVEL) begin
                     if (next_srch.found) begin
                        pos_in   = next_srch.pos;
                        phase_in = aswp_pkg::PH_POS;
                        level_in = '0;
                     end else begin
                        phase_in = aswp_pkg::PH_DONE;
                     end
                  end else begin
                     phase_in = aswp_pkg::PH_POS;
                  end
               end
            end
         end
         default: begin
            phase_in = aswp_pkg::PH_DONE;
         end
      endcase
   end

   // amplitude of the new level, zero beyond the last one
   always_comb begin
      amp_sel = '0;
      for (int i = 0; i < LEVEL_COUNT; i++) begin
         if (level_in == aswp_pkg::LEVEL_W'(i)) begin
            amp_sel = amp[i];
         end
      end
   end

   always_comb begin
      code   = ~pos_in;
      drive  = (phase_in == aswp_pkg::PH_NEG) ? (aswp_pkg::CMD_W'(0) - {1'b0, amp_sel})
                                               : {1'b0, amp_sel};
      result = '0;
      if (phase_in == aswp_pkg::PH_DONE) begin
         result.phase = aswp_pkg::PH_DONE;
      end else begin
         result.active_axis = code;
         result.phase       = phase_in;
         case (code)
            aswp_pkg::AXIS_X1: result.x1_command = drive;
            aswp_pkg::AXIS_X2: result.x2_command = drive;
            aswp_pkg::AXIS_Y1: result.y1_command = drive;
            default:           result.y2_command = drive;
         endcase
      end
   end

endmodule

`default_nettype wire

// ===== sv/axis_sweep_stimulus_sequencer.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Sweep stimulus sequencer for four axes. Every accepted transaction is one control tick carrying
// the at-max / at-min limit flags of the selected axis, and yields exactly one response
// transaction with the four q2.14 axis commands, the active axis and the sweep phase. Axes are
// visited y2, y1, x2, x1, skipping those masked off in the enable register; on each axis the
// configured amplitude levels are driven in turn, each level repeated repeats_per_level times
// as a full positive then negative swing. Once the last enabled axis is done the phase reads
// complete and all commands are zero. Throughput is one transaction per clock while rsp_stall
// does not hold a full output register: the tick is held in an input register, the step logic
// and level select sit in one combinational stage, and the response lands in an output
// register, where rsp_valid shows it until it is taken. req_stall rises only while the input
// register is full and the output register is held by rsp_stall. Configuration writes take
// effect from the next tick and should be done with no transaction in flight.
module axis_sweep_stimulus_sequencer #(
   parameter int LEVEL_COUNT = 5   // amplitude levels per axis, 1 to 5
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // tick input
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  aswp_pkg::req_type                       req_data,
   // command output
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output aswp_pkg::rsp_type                       rsp_data,
   // register writes
   input  wire logic                               csr_wr_en,
   input  wire logic [aswp_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [aswp_pkg::CSR_DATA_W-1:0]    csr_wr_data
);

   logic                        in_valid_ff, in_valid_in;
   aswp_pkg::req_type           in_data_ff;
   logic                        out_valid_ff, out_valid_in;
   aswp_pkg::rsp_type           out_data_ff;
   logic                        out_free;
   logic                        advance;
   logic                        req_take;
   aswp_pkg::cfg_type           cfg;
   logic [aswp_pkg::AMP_W-1:0]  amp [LEVEL_COUNT];
   aswp_pkg::rsp_type           step_result;

   // output register can take a new response when empty or being drained
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff && rsp_stall;
      if (advance) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= step_result;
      end
   end

   aswp_cfg #(
      .LEVEL_COUNT (LEVEL_COUNT)
   ) u_cfg (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .cfg         (cfg),
      .amp         (amp)
   );

   // sweep state advances once per tick moved into the output register
   aswp_seq #(
      .LEVEL_COUNT (LEVEL_COUNT)
   ) u_seq (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (in_data_ff),
      .cfg     (cfg),
      .amp     (amp),
      .result  (step_result)
   );

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

`default_nettype wire

// ===== sv/aswp_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module aswp_checker (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               req_stall,
   input wire logic                               rsp_valid,
   input wire logic                               rsp_stall,
   input aswp_pkg::rsp_type                       rsp_data
);

   // nothing comes out of a freshly reset block
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // a held response stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   // complete means every command at zero and axis field zero
   a_done_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.phase == aswp_pkg::PH_DONE |->
         rsp_data.x1_command == 0 && rsp_data.x2_command == 0 &&
         rsp_data.y1_command == 0 && rsp_data.y2_command == 0 &&
         rsp_data.active_axis == 0)
      else $error("commands not zero while complete");

   // only the active axis may carry drive
   a_one_axis: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         (rsp_data.active_axis == aswp_pkg::AXIS_X1 || rsp_data.x1_command == 0) &&
         (rsp_data.active_axis == aswp_pkg::AXIS_X2 || rsp_data.x2_command == 0) &&
         (rsp_data.active_axis == aswp_pkg::AXIS_Y1 || rsp_data.y1_command == 0) &&
         (rsp_data.active_axis == aswp_pkg::AXIS_Y2 || rsp_data.y2_command == 0))
      else $error("drive on an inactive axis");

   // a tick held in the input register by req_stall implies an occupied, stalled output
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled with output free");

endmodule

bind axis_sweep_stimulus_sequencer aswp_checker u_aswp_checker (
   .clock       (clock),
   .reset       (reset),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_data    (rsp_data)
);

`default_nettype wire
